### hw/rtl/cfdp_pdu_header_parser_defines.svh
// assertion macros shared by the cfdp header parser rtl
`ifndef CFDP_PDU_HEADER_PARSER_DEFINES_SVH
`define CFDP_PDU_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CFDP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CFDP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cfdp_hdr_pkg.sv
// types and constants shared by the cfdp header parser modules
`timescale 1ns / 1ps

package cfdp_hdr_pkg;

    localparam int POS_W  = 5;
    localparam int SIZE_W = 3;

    localparam logic [POS_W-1:0] HDR_FIXED_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] HDR_MAX_LEN   = POS_W'(28);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } hdr_item_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  version;
        logic        file_data;
        logic        direction;
        logic        unacknowledged;
        logic        crc_present;
        logic        large_file;
        logic [15:0] data_length;
        logic [1:0]  segment_flags;
        logic [63:0] source_id;
        logic [63:0] sequence_number;
        logic [63:0] dest_id;
    } hdr_result_t;

endpackage

### hw/rtl/cfdp_hdr_in_reg.sv
// input register stage holding one byte item
`timescale 1ns / 1ps

module cfdp_hdr_in_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  cfdp_hdr_pkg::hdr_item_t in_item,
    input  logic                    advance,
    output logic                    item_valid,
    output cfdp_hdr_pkg::hdr_item_t item
);
    import cfdp_hdr_pkg::*;

    logic      valid_reg;
    hdr_item_t item_reg;

    // held item blocks new input only while the result side cannot move
    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### hw/rtl/cfdp_hdr_parse.sv
// header field tracking and result forming for one byte per cycle
`timescale 1ns / 1ps
`include "cfdp_pdu_header_parser_defines.svh"

module cfdp_hdr_parse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  cfdp_hdr_pkg::hdr_item_t   item,
    output logic                      res_valid,
    output cfdp_hdr_pkg::hdr_result_t res
);
    import cfdp_hdr_pkg::*;

    localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SIZES  = POS_W'(3);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              done_reg, done_next;
    logic [7:0]        flag_reg, flag_next;
    logic [15:0]       len_reg, len_next;
    logic [SIZE_W-1:0] id_size_reg, id_size_next;
    logic [SIZE_W-1:0] seq_size_reg, seq_size_next;
    logic [1:0]        seg_reg, seg_next;
    logic [63:0]       src_reg, src_next;
    logic [63:0]       seqn_reg, seqn_next;
    logic [63:0]       dst_reg, dst_next;

    logic [POS_W-1:0]  id_len;
    logic [POS_W-1:0]  src_end;
    logic [POS_W-1:0]  seq_end;
    logic [POS_W-1:0]  total;
    logic [POS_W-1:0]  pos_inc;
    logic              hit;

    // section boundaries from the sizes latched at the length byte
    assign id_len  = POS_W'(id_size_reg) + POS_W'(1);
    assign src_end = HDR_FIXED_LEN + id_len;
    assign seq_end = src_end + POS_W'(seq_size_reg) + POS_W'(1);
    assign total   = seq_end + id_len;
    assign pos_inc = pos_reg + POS_W'(1);

    always_comb
    begin
        pos_next      = pos_reg;
        done_next     = done_reg;
        flag_next     = flag_reg;
        len_next      = len_reg;
        id_size_next  = id_size_reg;
        seq_size_next = seq_size_reg;
        seg_next      = seg_reg;
        src_next      = src_reg;
        seqn_next     = seqn_reg;
        dst_next      = dst_reg;
        hit           = 1'b0;
        res           = '0;
        res_valid     = 1'b0;

        if (item_valid && !done_reg)
        begin
            case (pos_reg)
                POS_FLAGS:
                begin
                    flag_next = item.data_byte;
                end
                POS_LEN_HI:
                begin
                    len_next = {item.data_byte, 8'h00};
                end
                POS_LEN_LO:
                begin
                    len_next = {len_reg[15:8], item.data_byte};
                end
                POS_SIZES:
                begin
                    id_size_next  = item.data_byte[6:4];
                    seq_size_next = item.data_byte[2:0];
                    seg_next      = {item.data_byte[7], item.data_byte[3]};
                end
                default:
                begin
                    if (pos_reg < src_end)
                    begin
                        src_next = {src_reg[55:0], item.data_byte};
                    end
                    else if (pos_reg < seq_end)
                    begin
                        seqn_next = {seqn_reg[55:0], item.data_byte};
                    end
                    else
                    begin
                        dst_next = {dst_reg[55:0], item.data_byte};
                    end
                end
            endcase

            pos_next = pos_inc;
            // total is at least seven, so the fixed bytes never match here
            if (pos_inc == total)
            begin
                done_next = 1'b1;
                hit       = 1'b1;
            end
        end

        if (hit)
        begin
            res_valid           = 1'b1;
            res.status          = STATUS_OK;
            res.version         = flag_next[7:5];
            res.file_data       = flag_next[4];
            res.direction       = flag_next[3];
            res.unacknowledged  = flag_next[2];
            res.crc_present     = flag_next[1];
            res.large_file      = flag_next[0];
            res.data_length     = len_next;
            res.segment_flags   = seg_next;
            res.source_id       = src_next;
            res.sequence_number = seqn_next;
            res.dest_id         = dst_next;
        end
        else if (item_valid && item.frame_end && !done_reg)
        begin
            res_valid  = 1'b1;
            res.status = STATUS_TRUNC;
        end

        // frame end rearms for the next frame
        if (item_valid && item.frame_end)
        begin
            pos_next      = '0;
            done_next     = 1'b0;
            flag_next     = '0;
            len_next      = '0;
            id_size_next  = '0;
            seq_size_next = '0;
            seg_next      = '0;
            src_next      = '0;
            seqn_next     = '0;
            dst_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            done_reg     <= 1'b0;
            flag_reg     <= '0;
            len_reg      <= '0;
            id_size_reg  <= '0;
            seq_size_reg <= '0;
            seg_reg      <= '0;
            src_reg      <= '0;
            seqn_reg     <= '0;
            dst_reg      <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            done_reg     <= done_next;
            flag_reg     <= flag_next;
            len_reg      <= len_next;
            id_size_reg  <= id_size_next;
            seq_size_reg <= seq_size_next;
            seg_reg      <= seg_next;
            src_reg      <= src_next;
            seqn_reg     <= seqn_next;
            dst_reg      <= dst_next;
        end
    end

    `CFDP_ASSERT_NXT(a_rearm_on_frame_end, item_valid && item.frame_end,
        pos_reg == '0 && !done_reg, "parser not rearmed after frame end")

    `CFDP_ASSERT_IMP(a_pos_in_range, 1'b1, pos_reg <= HDR_MAX_LEN,
        "header byte position beyond longest header")

    `CFDP_ASSERT_IMP(a_no_result_after_done, item_valid && done_reg, !res_valid,
        "result formed for a byte after the header")

    `CFDP_ASSERT_IMP(a_trunc_fields_zero, res_valid && res.status == STATUS_TRUNC,
        res.source_id == '0 && res.sequence_number == '0 && res.dest_id == '0
        && res.data_length == '0, "truncated result carries header fields")

endmodule

### hw/rtl/cfdp_hdr_out_reg.sv
// result register holding one parsed header until it is taken
`timescale 1ns / 1ps

module cfdp_hdr_out_reg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic                      res_valid,
    input  cfdp_hdr_pkg::hdr_result_t res,
    output logic                      out_valid,
    output cfdp_hdr_pkg::hdr_result_t out_res
);
    import cfdp_hdr_pkg::*;

    logic        valid_reg;
    hdr_result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

### hw/rtl/cfdp_pdu_header_parser.sv
// top level of the cfdp pdu fixed header parser
`timescale 1ns / 1ps

// path: an accepted byte is held in the input register, parsed combinationally, and its result
// is loaded into the result register when the pipe advances; a result-side stall holds it back
// throughput: one byte item per cycle while the result side keeps taking results
// the state update and field shift-in sit between the input register and result register
// reset: rst_n clears the header position, the done flag, sizes and all accumulators
// reset also empties the input register and result register
module cfdp_pdu_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    // byte item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    // parsed header channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [2:0]  version,
    output logic        file_data,
    output logic        direction,
    output logic        unacknowledged,
    output logic        crc_present,
    output logic        large_file,
    output logic [15:0] data_length,
    output logic [1:0]  segment_flags,
    output logic [63:0] source_id,
    output logic [63:0] sequence_number,
    output logic [63:0] dest_id
);
    import cfdp_hdr_pkg::*;

    hdr_item_t   in_item;
    hdr_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        parse_valid;
    logic        res_valid;
    hdr_result_t res;
    hdr_result_t out_res;

    assign in_item.data_byte = data_byte;
    assign in_item.frame_end = frame_end;

    // the whole pipe moves when the result register is empty or being drained
    assign advance     = !out_valid || !out_stall;
    // a held byte is consumed exactly when the pipe moves
    assign parse_valid = item_valid && advance;

    cfdp_hdr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // position tracking, size decode and big-endian shift-in of the ids
    cfdp_hdr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (parse_valid),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register parts the byte side from the result side
    cfdp_hdr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign status          = out_res.status;
    assign version         = out_res.version;
    assign file_data       = out_res.file_data;
    assign direction       = out_res.direction;
    assign unacknowledged  = out_res.unacknowledged;
    assign crc_present     = out_res.crc_present;
    assign large_file      = out_res.large_file;
    assign data_length     = out_res.data_length;
    assign segment_flags   = out_res.segment_flags;
    assign source_id       = out_res.source_id;
    assign sequence_number = out_res.sequence_number;
    assign dest_id         = out_res.dest_id;

endmodule

### dv/tb_cfdp_pdu_header_parser.sv
// self-checking testbench for the cfdp pdu fixed header parser
`timescale 1ns / 1ps

module tb_cfdp_pdu_header_parser;

    import cfdp_hdr_pkg::*;

    // run bounds: watchdog limit, receiver hold-off length and final drain wait
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [2:0]  version;
    logic        file_data;
    logic        direction;
    logic        unacknowledged;
    logic        crc_present;
    logic        large_file;
    logic [15:0] data_length;
    logic [1:0]  segment_flags;
    logic [63:0] source_id;
    logic [63:0] sequence_number;
    logic [63:0] dest_id;

    // bytes waiting to be offered, and headers the parser owes us
    hdr_item_t   byte_q[$];
    hdr_result_t header_q[$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned bytes_queued = 0;

    // idle percentages for each side, changed between phases
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    // long receiver hold-off requests, served by the receiver process
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    // set at the edge where the offered byte went in
    bit byte_taken = 1'b0;

    // parser state as the testbench tracks it
    logic [4:0]  hdr_pos = '0;
    logic        hdr_done = 1'b0;
    logic [7:0]  flags_reg = '0;
    logic [15:0] len_reg = '0;
    logic [2:0]  id_len_m1 = '0;
    logic [2:0]  seq_len_m1 = '0;
    logic [1:0]  seg_reg = '0;
    logic [63:0] src_acc = '0;
    logic [63:0] seq_acc = '0;
    logic [63:0] dst_acc = '0;

    cfdp_pdu_header_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .version         (version),
        .file_data       (file_data),
        .direction       (direction),
        .unacknowledged  (unacknowledged),
        .crc_present     (crc_present),
        .large_file      (large_file),
        .data_length     (data_length),
        .segment_flags   (segment_flags),
        .source_id       (source_id),
        .sequence_number (sequence_number),
        .dest_id         (dest_id)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // feed one accepted byte through the header parser and queue any header it yields
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        int          pos;
        int          e;
        int          s;
        int          total;
        hdr_result_t hdr;
        hdr = '0;
        if (!hdr_done)
        begin
            pos = hdr_pos;
            e = id_len_m1 + 1;
            s = seq_len_m1 + 1;
            if (pos == 0)
                flags_reg = b;
            else if (pos == 1)
                len_reg = {b, 8'h00};
            else if (pos == 2)
                len_reg[7:0] = b;
            else if (pos == 3)
            begin
                // length byte: entity id size, sequence size and the two segment bits
                id_len_m1 = b[6:4];
                seq_len_m1 = b[2:0];
                seg_reg = {b[7], b[3]};
                e = id_len_m1 + 1;
                s = seq_len_m1 + 1;
            end
            else if (pos < HDR_FIXED_LEN + e)
                src_acc = {src_acc[55:0], b};
            else if (pos < HDR_FIXED_LEN + e + s)
                seq_acc = {seq_acc[55:0], b};
            else
                dst_acc = {dst_acc[55:0], b};
            total = HDR_FIXED_LEN + e + s + e;
            hdr_pos = 5'(pos + 1);
            if (pos >= 3 && pos + 1 == total)
            begin
                hdr_done = 1'b1;
                hdr.status = STATUS_OK;
                hdr.version = flags_reg[7:5];
                hdr.file_data = flags_reg[4];
                hdr.direction = flags_reg[3];
                hdr.unacknowledged = flags_reg[2];
                hdr.crc_present = flags_reg[1];
                hdr.large_file = flags_reg[0];
                hdr.data_length = len_reg;
                hdr.segment_flags = seg_reg;
                hdr.source_id = src_acc;
                hdr.sequence_number = seq_acc;
                hdr.dest_id = dst_acc;
                header_q.push_back(hdr);
            end
        end
        if (last)
        begin
            // frame ended short of a full header: status only, all else zero
            if (!hdr_done)
            begin
                hdr = '0;
                hdr.status = STATUS_TRUNC;
                header_q.push_back(hdr);
            end
            // every frame end rearms the parser
            hdr_pos = '0;
            hdr_done = 1'b0;
            flags_reg = '0;
            len_reg = '0;
            id_len_m1 = '0;
            seq_len_m1 = '0;
            seg_reg = '0;
            src_acc = '0;
            seq_acc = '0;
            dst_acc = '0;
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] have);
        if (want !== have)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, have);
            errors++;
        end
    endtask

    // monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        hdr_result_t want;
        byte_taken = 1'b0;
        if (rst_n)
        begin
            // parsed header side
            if (out_valid && !out_stall)
            begin
                if (header_q.size() == 0)
                begin
                    $display("%0t ns: unexpected header, expected none, actual status %b",
                             $time, status);
                    errors++;
                end
                else
                begin
                    want = header_q.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("version", 64'(want.version), 64'(version));
                    check_field("file_data", 64'(want.file_data), 64'(file_data));
                    check_field("direction", 64'(want.direction), 64'(direction));
                    check_field("unacknowledged", 64'(want.unacknowledged),
                                64'(unacknowledged));
                    check_field("crc_present", 64'(want.crc_present), 64'(crc_present));
                    check_field("large_file", 64'(want.large_file), 64'(large_file));
                    check_field("data_length", 64'(want.data_length), 64'(data_length));
                    check_field("segment_flags", 64'(want.segment_flags),
                                64'(segment_flags));
                    check_field("source_id", want.source_id, source_id);
                    check_field("sequence_number", want.sequence_number, sequence_number);
                    check_field("dest_id", want.dest_id, dest_id);
                end
            end
            // byte side: the item at the head of the queue is the one on the bus
            if (in_valid && !in_stall)
            begin
                parse_byte(byte_q[0].data_byte, byte_q[0].frame_end);
                void'(byte_q.pop_front());
                byte_taken = 1'b1;
            end
        end
    end

    // driver: hold an offered byte until taken, otherwise offer the next or idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !byte_taken)
            begin
                // stalled, payload stays put
            end
            else if (byte_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                in_valid <= 1'b1;
                data_byte <= byte_q[0].data_byte;
                frame_end <= byte_q[0].frame_end;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** cfdp_pdu_header_parser: FAILED **");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        byte_q.push_back(hdr_item_t'{data_byte: b, frame_end: last});
        bytes_queued++;
    endtask

    // build one frame: header bytes from the fields, trailing bytes, optional early cut
    task automatic queue_frame(input logic [7:0] flags, input logic [15:0] dlen,
                               input logic [7:0] lbyte, input logic [63:0] src,
                               input logic [63:0] seqn, input logic [63:0] dst,
                               input int trail, input int cut);
        logic [7:0] bytes[$];
        int         e;
        int         s;
        e = lbyte[6:4] + 1;
        s = lbyte[2:0] + 1;
        bytes.push_back(flags);
        bytes.push_back(dlen[15:8]);
        bytes.push_back(dlen[7:0]);
        bytes.push_back(lbyte);
        for (int i = e - 1; i >= 0; i--)
            bytes.push_back(src[8*i +: 8]);
        for (int i = s - 1; i >= 0; i--)
            bytes.push_back(seqn[8*i +: 8]);
        for (int i = e - 1; i >= 0; i--)
            bytes.push_back(dst[8*i +: 8]);
        repeat (trail)
            bytes.push_back(8'($urandom_range(0, 255)));
        while (cut > 0 && bytes.size() > cut)
            void'(bytes.pop_back());
        foreach (bytes[i])
            push_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // mostly well-formed frames, some cut short, some raw noise
    task automatic random_frame();
        logic [7:0] lbyte;
        int         total;
        int         pick;
        lbyte = 8'($urandom_range(0, 255));
        total = HDR_FIXED_LEN + 2 * (lbyte[6:4] + 1) + lbyte[2:0] + 1;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            queue_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), lbyte,
                        {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        $urandom_range(0, 3), 0);
        else if (pick < 90)
            queue_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), lbyte,
                        {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        0, $urandom_range(1, total - 1));
        else
        begin
            // noise with stray frame ends, closed by a frame end to realign
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || header_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned stop_at;
        stop_at = bytes_queued + count;
        while (bytes_queued < stop_at)
            random_frame();
    endtask

    initial
    begin
        // directed frames
        // single byte frame: truncated at the flags byte
        push_byte(8'hA5, 1'b1);
        // all-ones flags and length, smallest ids, both segment bits set, ends on last byte
        queue_frame(8'hFF, 16'hFFFF, 8'h88, 64'hFF, 64'hFF, 64'hFF, 0, 0);
        // all-zero header with trailing bytes that the parser ignores
        queue_frame(8'h00, 16'h0000, 8'h00, 64'h00, 64'h00, 64'h00, 2, 0);
        // cut right after the length byte
        queue_frame(8'h3C, 16'h1234, 8'h77, 64'h0, 64'h0, 64'h0, 0, 4);

        tx_idle_pct = 31;
        rx_idle_pct = 64;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // largest header: eight byte ids and sequence number
        queue_frame(8'h5A, 16'hA55A, 8'h77, 64'hFEDCBA9876543210, 64'h0123456789ABCDEF,
                    64'h8000000000000001, 1, 0);
        random_phase(600);
        // sender pauses until every header is back
        wait_drained();

        tx_idle_pct = 64;
        rx_idle_pct = 31;
        random_phase(600);
        wait_drained();

        // long receiver hold-off while single byte frames pour in, filling the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        repeat (60)
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        random_phase(40);
        wait_drained();

        // back to back, no idling on either side
        random_phase(520);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && header_q.size() == 0)
            $display("** cfdp_pdu_header_parser: PASSED **");
        else
            $display("** cfdp_pdu_header_parser: FAILED **");
        $finish;
    end

endmodule
